// ===== hdl/tilt_platform_inverse_kinematics_top_macros.svh =====
// Assertion macros used by the checker file.
`ifndef TILT_PLATFORM_INVERSE_KINEMATICS_TOP_MACROS_SVH
`define TILT_PLATFORM_INVERSE_KINEMATICS_TOP_MACROS_SVH

// Clocked property, masked while reset is high.
`define TPIK_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Clocked property that also holds across reset.
`define TPIK_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

// ===== hdl/tpik_pkg.sv =====
// ----------------------------------------------------------------------------
// tpik_pkg
// Types, codes and constants of the tilt platform inverse kinematics block.
// ----------------------------------------------------------------------------
package tpik_pkg;

  localparam int CFG_W   = 20;
  localparam int IDX_W   = 3;
  localparam int ANG_W   = 15;
  localparam int SEL_W   = 2;
  localparam int OANG_W  = 14;
  localparam int STAT_W  = 2;
  localparam int QUEUE_DEPTH = 2;

  // register indexes
  localparam logic [IDX_W-1:0] REG_HEIGHT = 3'd0;
  localparam logic [IDX_W-1:0] REG_RADIUS = 3'd1;
  localparam logic [IDX_W-1:0] REG_OFFSET = 3'd2;
  localparam logic [IDX_W-1:0] REG_CRANK  = 3'd3;
  localparam logic [IDX_W-1:0] REG_ROD    = 3'd4;

  localparam logic [CFG_W-1:0] RST_HEIGHT = 20'd81000;
  localparam logic [CFG_W-1:0] RST_RADIUS = 20'd45000;
  localparam logic [CFG_W-1:0] RST_OFFSET = 20'd49220;
  localparam logic [CFG_W-1:0] RST_CRANK  = 20'd60550;
  localparam logic [CFG_W-1:0] RST_ROD    = 20'd51260;

  // fold limits, hundredths of a degree
  localparam logic signed [ANG_W:0] ANG_POS_LIM  = 16'sd9000;
  localparam logic signed [ANG_W:0] ANG_NEG_LIM  = -16'sd9000;
  localparam logic signed [ANG_W:0] ANG_HALF_TURN = 16'sd18000;
  localparam logic [16:0] OANG_MAX = 17'd9000;

  // Q30 constants
  localparam logic signed [31:0] Q30_ONE        = 32'sd1073741824;
  localparam logic signed [31:0] Q30_HALF       = 32'sd536870912;
  localparam logic signed [31:0] Q30_SQRT3_HALF = 32'sd929887697;
  localparam logic signed [33:0] CORDIC_INV_GAIN = 34'sd652032874;

  localparam logic [SEL_W-1:0] SEL_PLUS  = 2'd1;
  localparam logic [SEL_W-1:0] SEL_MINUS = 2'd2;

  typedef enum logic [STAT_W-1:0] {
    STAT_OK    = 2'd0,
    STAT_NOSOL = 2'd1,
    STAT_ZERO  = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    MOT_ZERO,
    MOT_PLUS,
    MOT_MINUS
  } motor_t;

  typedef struct packed {
    logic [CFG_W-1:0] height;
    logic [CFG_W-1:0] radius;
    logic [CFG_W-1:0] offset;
    logic [CFG_W-1:0] crank;
    logic [CFG_W-1:0] rod;
  } cfg_t;

  // one classified item in the queue
  typedef struct packed {
    logic signed [ANG_W-1:0] roll;
    logic                    roll_neg;
    logic signed [ANG_W-1:0] pitch;
    logic                    pitch_neg;
    motor_t                  motor;
  } item_t;

  typedef struct packed {
    logic push;
    logic full;
  } qctl_t;

  typedef enum logic [4:0] {
    BK_IDLE,
    BK_TRIG,
    BK_MUL2,
    BK_MUL3,
    BK_CHK,
    BK_SQ,
    BK_NUM,
    BK_SQRT1,
    BK_BND,
    BK_CMP,
    BK_DIV,
    BK_TSQ,
    BK_ROOT2,
    BK_SQRT2,
    BK_MUL4,
    BK_SUM,
    BK_NORM,
    BK_VEC,
    BK_FIN,
    BK_OUT
  } back_state_t;

  // atan(2^-i), hundredths of a degree, Q8
  function automatic logic [20:0] atan_entry(input logic [4:0] idx);
    logic [20:0] v;
    unique case (idx)
      5'd0:  v = 21'd1152000;
      5'd1:  v = 21'd680065;
      5'd2:  v = 21'd359328;
      5'd3:  v = 21'd182400;
      5'd4:  v = 21'd91554;
      5'd5:  v = 21'd45822;
      5'd6:  v = 21'd22916;
      5'd7:  v = 21'd11459;
      5'd8:  v = 21'd5730;
      5'd9:  v = 21'd2865;
      5'd10: v = 21'd1432;
      5'd11: v = 21'd716;
      5'd12: v = 21'd358;
      5'd13: v = 21'd179;
      5'd14: v = 21'd90;
      5'd15: v = 21'd45;
      5'd16: v = 21'd22;
      5'd17: v = 21'd11;
      5'd18: v = 21'd6;
      5'd19: v = 21'd3;
      5'd20: v = 21'd1;
      5'd21: v = 21'd1;
      default: v = 21'd0;
    endcase
    return v;
  endfunction

endpackage

// ===== hdl/tpik_if.sv =====
// ----------------------------------------------------------------------------
// tpik_if
// Valid/ready channels: joint angle request in, motor angle result out.
// ----------------------------------------------------------------------------
interface tpik_in_if;
  logic                                  valid;
  logic                                  ready;
  logic signed [tpik_pkg::ANG_W-1:0]     roll_angle;
  logic signed [tpik_pkg::ANG_W-1:0]     pitch_angle;
  logic        [tpik_pkg::SEL_W-1:0]     motor_select;

  modport source(output valid, roll_angle, pitch_angle, motor_select, input ready);
  modport sink(input valid, roll_angle, pitch_angle, motor_select, output ready);
endinterface

interface tpik_out_if;
  logic                              valid;
  logic                              ready;
  logic [tpik_pkg::OANG_W-1:0]       motor_angle;
  logic [tpik_pkg::STAT_W-1:0]       status;

  modport source(output valid, motor_angle, status, input ready);
  modport sink(input valid, motor_angle, status, output ready);
endinterface

// ===== hdl/tpik_front.sv =====
// ----------------------------------------------------------------------------
// tpik_front
// Accepts requests, folds angles into +-90 degrees and decodes the motor.
// ----------------------------------------------------------------------------
module tpik_front (
  tpik_in_if.sink            in_ch,
  input  logic               q_full,
  output logic               q_push,
  output tpik_pkg::item_t    q_item
);

  logic signed [tpik_pkg::ANG_W:0] roll_x, pitch_x, roll_f, pitch_f;
  logic roll_neg, pitch_neg;

  assign in_ch.ready = !q_full;
  assign q_push      = in_ch.valid && !q_full;

  always_comb begin
    roll_x  = {in_ch.roll_angle[tpik_pkg::ANG_W-1], in_ch.roll_angle};
    pitch_x = {in_ch.pitch_angle[tpik_pkg::ANG_W-1], in_ch.pitch_angle};
    roll_neg  = 1'b1;
    pitch_neg = 1'b1;
    // beyond ninety: mirror the angle, cosine changes sign
    priority if (roll_x > tpik_pkg::ANG_POS_LIM) begin
      roll_f = tpik_pkg::ANG_HALF_TURN - roll_x;
    end else if (roll_x < tpik_pkg::ANG_NEG_LIM) begin
      roll_f = -tpik_pkg::ANG_HALF_TURN - roll_x;
    end else begin
      roll_f   = roll_x;
      roll_neg = 1'b0;
    end
    priority if (pitch_x > tpik_pkg::ANG_POS_LIM) begin
      pitch_f = tpik_pkg::ANG_HALF_TURN - pitch_x;
    end else if (pitch_x < tpik_pkg::ANG_NEG_LIM) begin
      pitch_f = -tpik_pkg::ANG_HALF_TURN - pitch_x;
    end else begin
      pitch_f   = pitch_x;
      pitch_neg = 1'b0;
    end
    q_item.roll      = roll_f[tpik_pkg::ANG_W-1:0];
    q_item.roll_neg  = roll_neg;
    q_item.pitch     = pitch_f[tpik_pkg::ANG_W-1:0];
    q_item.pitch_neg = pitch_neg;
    priority if (in_ch.motor_select == tpik_pkg::SEL_PLUS) begin
      q_item.motor = tpik_pkg::MOT_PLUS;
    end else if (in_ch.motor_select == tpik_pkg::SEL_MINUS) begin
      q_item.motor = tpik_pkg::MOT_MINUS;
    end else begin
      q_item.motor = tpik_pkg::MOT_ZERO;
    end
  end

endmodule

// ===== hdl/tpik_queue.sv =====
// ----------------------------------------------------------------------------
// tpik_queue
// Short register queue between the front and the back.
// ----------------------------------------------------------------------------
module tpik_queue (
  input  logic               clk,
  input  logic               rst,
  input  tpik_pkg::qctl_t    ctl_in,
  output logic               full,
  input  tpik_pkg::item_t    wr_item,
  input  logic               pop,
  output logic               not_empty,
  output tpik_pkg::item_t    rd_item
);

  localparam int PTR_W = $clog2(tpik_pkg::QUEUE_DEPTH);
  localparam int CNT_W = $clog2(tpik_pkg::QUEUE_DEPTH + 1);

  tpik_pkg::item_t  entries [tpik_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr, rd_ptr;
  logic [CNT_W-1:0] count;
  logic do_pop;

  assign full      = (count == CNT_W'(tpik_pkg::QUEUE_DEPTH));
  assign not_empty = (count != '0);
  assign rd_item   = entries[rd_ptr];
  assign do_pop    = pop && not_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (ctl_in.push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      count <= count + CNT_W'(ctl_in.push) - CNT_W'(do_pop);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl_in.push) begin
      entries[wr_ptr] <= wr_item;
    end
  end

endmodule

// ===== hdl/tpik_isqrt.sv =====
// ----------------------------------------------------------------------------
// tpik_isqrt
// Floor square root of a 62-bit value, one result bit per cycle.
// ----------------------------------------------------------------------------
module tpik_isqrt (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic [61:0] arg,
  output logic        done,
  output logic [30:0] root
);

  logic        busy;
  logic [4:0]  cnt;
  logic [61:0] op;
  logic [34:0] rem, rem_sh, trial;

  always_comb begin
    rem_sh = {rem[32:0], op[61:60]};
    trial  = {2'b00, root, 2'b01};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= 5'd30;
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == 5'd0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      op   <= arg;
      rem  <= '0;
      root <= '0;
    end else if (busy) begin
      op <= {op[59:0], 2'b00};
      if (rem_sh >= trial) begin
        rem  <= rem_sh - trial;
        root <= {root[29:0], 1'b1};
      end else begin
        rem  <= rem_sh;
        root <= {root[29:0], 1'b0};
      end
    end
  end

endmodule

// ===== hdl/tpik_back.sv =====
// ----------------------------------------------------------------------------
// tpik_back
// Sequencer that runs the kinematics of one queued item and holds the result.
// ----------------------------------------------------------------------------
module tpik_back #(
  parameter int CORDIC_ITERATIONS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  tpik_pkg::cfg_t     cfg,
  input  logic               q_valid,
  input  tpik_pkg::item_t    q_item,
  output logic               q_pop,
  output logic               sq_start,
  output logic [61:0]        sq_arg,
  input  logic               sq_done,
  input  logic [30:0]        sq_root,
  tpik_out_if.source         out_ch
);

  localparam int ITW = (CORDIC_ITERATIONS > 1) ? $clog2(CORDIC_ITERATIONS) : 1;
  localparam logic [ITW-1:0] ITER_LAST = ITW'(CORDIC_ITERATIONS - 1);

  tpik_pkg::back_state_t state, state_next;
  tpik_pkg::item_t item;

  logic [ITW-1:0] iter;
  logic signed [33:0] rx, ry, px_c, py_c;
  logic signed [24:0] rz, pz_c, at;
  logic signed [30:0] x8, y8;
  logic signed [31:0] px, t1, ay, pzv, s;
  logic [61:0] d2, hin;
  logic [55:0] l1sq;
  logic signed [63:0] diff, num;
  logic [30:0] d, hgt;
  logic [59:0] bound;
  logic [62:0] nabs, vx, vy;
  logic [31:0] rem, dvs;
  logic [28:0] dlow, q;
  logic [4:0]  dcnt;
  logic signed [29:0] t;
  logic signed [63:0] p_tw, p_hs, p_hw, p_ts;
  logic [tpik_pkg::OANG_W-1:0] res_angle;
  tpik_pkg::status_t res_status;
  logic out_valid;
  logic [tpik_pkg::OANG_W-1:0] out_angle;
  tpik_pkg::status_t out_status;

  // combinational datapath terms
  logic signed [31:0] ct, st;
  logic signed [52:0] m_x, m_y;
  logic signed [33:0] ca, cb, sa, sb;
  logic signed [64:0] m_px, m_t1, m_ay;
  logic signed [65:0] m_ct;
  logic signed [33:0] pz_sum;
  logic [27:0] l1, l2, bo8;
  logic [27:0] h8;
  logic signed [63:0] m_ss, m_ww;
  logic [58:0] m_bnd;
  logic signed [29:0] tq, t_new;
  logic signed [59:0] m_tt;
  logic signed [31:0] hgt_s;
  logic signed [63:0] zc, uc;
  logic [62:0] v_or;
  logic big4, big1;
  logic signed [24:0] zpos;
  logic [16:0] ang_r;
  logic [32:0] div_r;
  logic div_ge;

  assign at = $signed({4'b0000, tpik_pkg::atan_entry(5'(iter))});
  assign l1  = {cfg.crank, 8'h00};
  assign l2  = {cfg.rod, 8'h00};
  assign bo8 = {cfg.offset, 8'h00};
  assign h8  = {cfg.height, 8'h00};

  always_comb begin
    // motor zero: no turn about Z
    ct = tpik_pkg::Q30_ONE;
    st = 32'sd0;
    unique case (q_item.motor)
      tpik_pkg::MOT_PLUS: begin
        ct = -tpik_pkg::Q30_HALF;
        st = tpik_pkg::Q30_SQRT3_HALF;
      end
      tpik_pkg::MOT_MINUS: begin
        ct = -tpik_pkg::Q30_HALF;
        st = -tpik_pkg::Q30_SQRT3_HALF;
      end
      default: begin
      end
    endcase
    m_x = $signed({1'b0, cfg.radius}) * ct + 53'sd2097152;
    m_y = $signed({1'b0, cfg.radius}) * st + 53'sd2097152;

    ca = item.roll_neg  ? -rx   : rx;
    sa = ry;
    cb = item.pitch_neg ? -px_c : px_c;
    sb = py_c;
    m_px = cb * x8 + 65'sd536870912;
    m_t1 = sb * x8 + 65'sd536870912;
    m_ay = sa * y8 + 65'sd536870912;
    m_ct = ca * t1 + 66'sd536870912;
    pz_sum = $signed({6'd0, h8}) + 34'(ay) - 34'(m_ct[65:30]);

    m_ss = s * s;
    m_ww = pzv * pzv;
    m_bnd = d * l1;

    tq    = $signed({1'b0, q});
    t_new = num[63] ? -tq : tq;
    m_tt  = t_new * t_new;

    hgt_s = $signed({1'b0, hgt});
    if (!pzv[31] && (pzv != 32'sd0)) begin
      zc = p_tw + p_hs;
      uc = p_hw - p_ts;
    end else begin
      zc = p_tw - p_hs;
      uc = -p_hw - p_ts;
    end

    v_or = vx | vy;
    big4 = |v_or[62:33];
    big1 = |v_or[62:30];

    zpos  = rz[24] ? 25'sd0 : rz;
    ang_r = 17'((zpos + 25'sd128) >>> 8);

    div_r  = {rem, dlow[28]};
    div_ge = (div_r >= {1'b0, dvs});
  end

  // ---- control ----
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tpik_pkg::BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    q_pop      = 1'b0;
    sq_start   = 1'b0;
    sq_arg     = d2;
    unique case (state)
      tpik_pkg::BK_IDLE: begin
        if (q_valid) begin
          q_pop      = 1'b1;
          state_next = tpik_pkg::BK_TRIG;
        end
      end
      tpik_pkg::BK_TRIG: begin
        if (iter == ITER_LAST) state_next = tpik_pkg::BK_MUL2;
      end
      tpik_pkg::BK_MUL2: state_next = tpik_pkg::BK_MUL3;
      tpik_pkg::BK_MUL3: state_next = tpik_pkg::BK_CHK;
      tpik_pkg::BK_CHK: begin
        state_next = (pzv == 32'sd0) ? tpik_pkg::BK_OUT : tpik_pkg::BK_SQ;
      end
      tpik_pkg::BK_SQ: state_next = tpik_pkg::BK_NUM;
      tpik_pkg::BK_NUM: begin
        sq_start   = 1'b1;
        state_next = tpik_pkg::BK_SQRT1;
      end
      tpik_pkg::BK_SQRT1: begin
        if (sq_done) state_next = tpik_pkg::BK_BND;
      end
      tpik_pkg::BK_BND: state_next = tpik_pkg::BK_CMP;
      tpik_pkg::BK_CMP: begin
        state_next = (nabs > {3'b000, bound}) ? tpik_pkg::BK_OUT : tpik_pkg::BK_DIV;
      end
      tpik_pkg::BK_DIV: begin
        if (dcnt == 5'd0) state_next = tpik_pkg::BK_TSQ;
      end
      tpik_pkg::BK_TSQ: state_next = tpik_pkg::BK_ROOT2;
      tpik_pkg::BK_ROOT2: begin
        sq_start   = 1'b1;
        sq_arg     = hin;
        state_next = tpik_pkg::BK_SQRT2;
      end
      tpik_pkg::BK_SQRT2: begin
        if (sq_done) state_next = tpik_pkg::BK_MUL4;
      end
      tpik_pkg::BK_MUL4: state_next = tpik_pkg::BK_SUM;
      tpik_pkg::BK_SUM:  state_next = tpik_pkg::BK_NORM;
      tpik_pkg::BK_NORM: begin
        if (!big1) state_next = tpik_pkg::BK_VEC;
      end
      tpik_pkg::BK_VEC: begin
        if (iter == ITER_LAST) state_next = tpik_pkg::BK_FIN;
      end
      tpik_pkg::BK_FIN: state_next = tpik_pkg::BK_OUT;
      tpik_pkg::BK_OUT: begin
        if (!out_valid || out_ch.ready) state_next = tpik_pkg::BK_IDLE;
      end
      default: state_next = tpik_pkg::BK_IDLE;
    endcase
  end

  // ---- datapath ----
  always_ff @(posedge clk) begin
    unique case (state)
      tpik_pkg::BK_IDLE: begin
        item <= q_item;
        iter <= '0;
        rx   <= tpik_pkg::CORDIC_INV_GAIN;
        ry   <= 34'sd0;
        rz   <= {{2{q_item.roll[14]}}, q_item.roll, 8'h00};
        px_c <= tpik_pkg::CORDIC_INV_GAIN;
        py_c <= 34'sd0;
        pz_c <= {{2{q_item.pitch[14]}}, q_item.pitch, 8'h00};
        x8   <= m_x[52:22];
        y8   <= m_y[52:22];
        res_angle  <= '0;
        res_status <= tpik_pkg::STAT_OK;
      end
      tpik_pkg::BK_TRIG: begin
        iter <= iter + 1'b1;
        if (!rz[24]) begin
          rx <= rx - (ry >>> iter);
          ry <= ry + (rx >>> iter);
          rz <= rz - at;
        end else begin
          rx <= rx + (ry >>> iter);
          ry <= ry - (rx >>> iter);
          rz <= rz + at;
        end
        if (!pz_c[24]) begin
          px_c <= px_c - (py_c >>> iter);
          py_c <= py_c + (px_c >>> iter);
          pz_c <= pz_c - at;
        end else begin
          px_c <= px_c + (py_c >>> iter);
          py_c <= py_c - (px_c >>> iter);
          pz_c <= pz_c + at;
        end
      end
      tpik_pkg::BK_MUL2: begin
        px <= m_px[61:30];
        t1 <= m_t1[61:30];
        ay <= m_ay[61:30];
      end
      tpik_pkg::BK_MUL3: begin
        pzv <= pz_sum[31:0];
        s   <= px - $signed({4'h0, bo8});
      end
      tpik_pkg::BK_CHK: begin
        if (pzv == 32'sd0) res_status <= tpik_pkg::STAT_ZERO;
      end
      tpik_pkg::BK_SQ: begin
        d2   <= m_ss[61:0] + m_ww[61:0];
        l1sq <= l1 * l1;
        diff <= $signed({8'h00, 56'(l1 * l1)}) - $signed({8'h00, 56'(l2 * l2)});
      end
      tpik_pkg::BK_NUM: begin
        num <= diff + $signed({2'b00, d2});
      end
      tpik_pkg::BK_SQRT1: begin
        if (sq_done) d <= sq_root;
      end
      tpik_pkg::BK_BND: begin
        bound <= {m_bnd, 1'b0};
        nabs  <= num[63] ? 63'(-num) : num[62:0];
      end
      tpik_pkg::BK_CMP: begin
        if (nabs > {3'b000, bound}) res_status <= tpik_pkg::STAT_NOSOL;
        // quotient fits 29 bits, so the top part starts below the divisor
        rem  <= nabs[60:29];
        dlow <= nabs[28:0];
        dvs  <= {d, 1'b0};
        dcnt <= 5'd28;
        q    <= '0;
      end
      tpik_pkg::BK_DIV: begin
        dcnt <= dcnt - 1'b1;
        dlow <= {dlow[27:0], 1'b0};
        if (div_ge) begin
          rem <= 32'(div_r - {1'b0, dvs});
          q   <= {q[27:0], 1'b1};
        end else begin
          rem <= div_r[31:0];
          q   <= {q[27:0], 1'b0};
        end
      end
      tpik_pkg::BK_TSQ: begin
        t   <= t_new;
        hin <= {6'd0, l1sq - m_tt[55:0]};
      end
      tpik_pkg::BK_SQRT2: begin
        if (sq_done) hgt <= sq_root;
      end
      tpik_pkg::BK_MUL4: begin
        p_tw <= 64'(t * pzv);
        p_hs <= hgt_s * s;
        p_hw <= hgt_s * pzv;
        p_ts <= 64'(t * s);
      end
      tpik_pkg::BK_SUM: begin
        vx <= uc[63] ? 63'(-uc) : uc[62:0];
        vy <= zc[63] ? 63'(-zc) : zc[62:0];
      end
      tpik_pkg::BK_NORM: begin
        iter <= '0;
        if (big4) begin
          vx <= vx >> 4;
          vy <= vy >> 4;
        end else if (big1) begin
          vx <= vx >> 1;
          vy <= vy >> 1;
        end
        rx <= $signed({4'h0, vx[29:0]});
        ry <= $signed({4'h0, vy[29:0]});
        rz <= 25'sd0;
      end
      tpik_pkg::BK_VEC: begin
        iter <= iter + 1'b1;
        if (!ry[33]) begin
          rx <= rx + (ry >>> iter);
          ry <= ry - (rx >>> iter);
          rz <= rz + at;
        end else begin
          rx <= rx - (ry >>> iter);
          ry <= ry + (rx >>> iter);
          rz <= rz - at;
        end
      end
      tpik_pkg::BK_FIN: begin
        res_angle  <= (ang_r > tpik_pkg::OANG_MAX) ?
                      tpik_pkg::OANG_MAX[tpik_pkg::OANG_W-1:0] :
                      ang_r[tpik_pkg::OANG_W-1:0];
        res_status <= tpik_pkg::STAT_OK;
      end
      default: begin
      end
    endcase
  end

  // ---- result register ----
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == tpik_pkg::BK_OUT && (!out_valid || out_ch.ready)) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == tpik_pkg::BK_OUT && (!out_valid || out_ch.ready)) begin
      out_angle  <= res_angle;
      out_status <= res_status;
    end
  end

  assign out_ch.valid       = out_valid;
  assign out_ch.motor_angle = out_angle;
  assign out_ch.status      = out_status;

endmodule

// ===== hdl/tilt_platform_inverse_kinematics_top.sv =====
// ----------------------------------------------------------------------------
// tilt_platform_inverse_kinematics_top
// Crank angle of one motor of a three-crank tilting platform.
// ----------------------------------------------------------------------------
// Usage:
//   in_ch carries roll, pitch (hundredths of a degree) and a motor number;
//   out_ch returns one crank angle and a status per request, in order.
//   Geometry registers are written through cfg_write/cfg_index/cfg_data
//   while no request is in flight; they take effect for the next request.
// Timing:
//   A request is taken into a two-entry queue whenever the queue is not
//   full. The sequencer then runs two CORDIC passes, two square roots
//   and a divide one after another, with range-scaling steps between the
//   second root and the second CORDIC pass. Anchor on the base plane
//   finishes after the first CORDIC pass, no circle intersection after
//   the first square root. Throughput is one result per pass.
// Reset:
//   Synchronous; clears the queue, sequencer and output valid, and loads
//   the default geometry. If out_ch stalls, the result is held, the next
//   request is computed and waits, and the queue fills before in_ch stalls.
// ----------------------------------------------------------------------------
module tilt_platform_inverse_kinematics_top #(
  parameter int CORDIC_ITERATIONS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          cfg_write,
  input  logic [tpik_pkg::IDX_W-1:0]    cfg_index,
  input  logic [tpik_pkg::CFG_W-1:0]    cfg_data,
  tpik_in_if.sink                       in_ch,
  tpik_out_if.source                    out_ch
);

  tpik_pkg::cfg_t  cfg;
  tpik_pkg::item_t f_item, q_item;
  tpik_pkg::qctl_t qctl;
  logic q_push, q_full, q_valid, q_pop;
  logic sq_start, sq_done;
  logic [61:0] sq_arg;
  logic [30:0] sq_root;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.height <= tpik_pkg::RST_HEIGHT;
      cfg.radius <= tpik_pkg::RST_RADIUS;
      cfg.offset <= tpik_pkg::RST_OFFSET;
      cfg.crank  <= tpik_pkg::RST_CRANK;
      cfg.rod    <= tpik_pkg::RST_ROD;
    end else if (cfg_write) begin
      unique case (cfg_index)
        tpik_pkg::REG_HEIGHT: cfg.height <= cfg_data;
        tpik_pkg::REG_RADIUS: cfg.radius <= cfg_data;
        tpik_pkg::REG_OFFSET: cfg.offset <= cfg_data;
        tpik_pkg::REG_CRANK:  cfg.crank  <= cfg_data;
        tpik_pkg::REG_ROD:    cfg.rod    <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  assign qctl.push = q_push;
  assign qctl.full = q_full;

  tpik_front u_front (
    .in_ch  (in_ch),
    .q_full (q_full),
    .q_push (q_push),
    .q_item (f_item)
  );

  tpik_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .ctl_in    (qctl),
    .full      (q_full),
    .wr_item   (f_item),
    .pop       (q_pop),
    .not_empty (q_valid),
    .rd_item   (q_item)
  );

  tpik_isqrt u_isqrt (
    .clk   (clk),
    .rst   (rst),
    .start (sq_start),
    .arg   (sq_arg),
    .done  (sq_done),
    .root  (sq_root)
  );

  tpik_back #(
    .CORDIC_ITERATIONS (CORDIC_ITERATIONS)
  ) u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop),
    .sq_start (sq_start),
    .sq_arg   (sq_arg),
    .sq_done  (sq_done),
    .sq_root  (sq_root),
    .out_ch   (out_ch)
  );

endmodule

// ===== hdl/tpik_checker.sv =====
// ----------------------------------------------------------------------------
// tpik_checker
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
`include "tilt_platform_inverse_kinematics_top_macros.svh"

module tpik_checker (
  input logic                            clk,
  input logic                            rst,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic [tpik_pkg::OANG_W-1:0]     motor_angle,
  input logic [tpik_pkg::STAT_W-1:0]     status
);

  `TPIK_ASSERT(a_err_zero_angle, out_valid && (status != tpik_pkg::STAT_OK) |-> motor_angle == '0, "error result carries an angle")
  `TPIK_ASSERT(a_angle_range, out_valid |-> motor_angle <= tpik_pkg::OANG_W'(9000), "angle above ninety degrees")
  `TPIK_ASSERT(a_hold, out_valid && !out_ready |=> out_valid && $stable(motor_angle) && $stable(status), "stalled beat changed")
  `TPIK_ASSERT_ALWAYS(a_rst_quiet, $past(rst) |-> !out_valid, "result valid right after reset")

endmodule

bind tilt_platform_inverse_kinematics_top tpik_checker u_tpik_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (out_ch.valid),
  .out_ready   (out_ch.ready),
  .motor_angle (out_ch.motor_angle),
  .status      (out_ch.status)
);
